// ===== hw/rtl/peak_normalize_gain_saturate_top_assert.svh =====
// Assertion macros used by the RTL core of the peak normaliser.
`ifndef PEAK_NORMALIZE_GAIN_SATURATE_TOP_ASSERT_SVH
`define PEAK_NORMALIZE_GAIN_SATURATE_TOP_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define PNGS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define PNGS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pngs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pngs_pkg;

  localparam int SMP_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int SF_W      = 40;
  localparam int ALU_W     = 58;
  localparam int DVD_W     = 36;
  localparam int REM_W     = 17;
  localparam int MUL_STEPS = 16;
  localparam int CNT_W     = $clog2(DVD_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [SMP_W-1:0]  SAT_LIMIT  = 16'd32766;
  localparam logic [SMP_W-1:0]  SAT_POS    = 16'h7FFE;
  localparam logic [SMP_W-1:0]  SAT_NEG    = 16'h8002;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd4096;
  localparam logic [SF_W-1:0]   UNITY_Q16  = SF_W'(65536);
  localparam logic [ALU_W-1:0]  NORM_TOL   = ALU_W'(134218);
  localparam logic [ALU_W-1:0]  RND_HALF   = ALU_W'(32768);

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b1;

  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_APPLY   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LATCH,
    ST_DIFF,
    ST_ABS,
    ST_TOL,
    ST_NABS,
    ST_DVD,
    ST_DIV,
    ST_SIGN,
    ST_FABS,
    ST_MUL,
    ST_RND,
    ST_SAT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_op_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              normalize_mode;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic [SMP_W-1:0]  sample;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [SMP_W-1:0]  scaled;
    logic              clipped;
    logic              frame_end;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pngs_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pngs_alu (
  input  pngs_pkg::alu_op_t               op,
  output logic [pngs_pkg::ALU_W-1:0]      sum
);
  import pngs_pkg::*;

  assign sum = op.a + (op.sub ? ~op.b : op.b) + ALU_W'(op.sub);

endmodule

`default_nettype wire

// ===== hw/rtl/pngs_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "peak_normalize_gain_saturate_top_assert.svh"

module pngs_core (
  input  logic            clk,
  input  logic            rst_n,
  input  pngs_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  pngs_pkg::item_t item,
  output logic            res_valid,
  input  logic            res_ready,
  output pngs_pkg::res_t  res
);
  import pngs_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SMP_W-1:0]    peak_r, peak_nxt;
  logic [SF_W-1:0]     sf_r, sf_nxt;
  logic                pu_r, pu_nxt;
  logic [ALU_W-1:0]    acc_r, acc_nxt;
  logic [ALU_W-1:0]    opd_r, opd_nxt;
  logic [DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [SMP_W-1:0]    smag_r, smag_nxt;
  logic                neg_r, neg_nxt;
  logic                last_r, last_nxt;
  res_t                res_r, res_nxt;

  alu_op_t             op;
  logic [ALU_W-1:0]    sum;
  logic [ALU_W-1:0]    gain_ext;
  logic [SMP_W-1:0]    in_mag;
  logic [REM_W:0]      rem_sh;
  logic                qbit;
  logic                clip;
  logic [SMP_W-1:0]    sat_mag;

  pngs_alu u_alu (
    .op  (op),
    .sum (sum)
  );

  assign gain_ext = {{(ALU_W-GAIN_W){cfg.gain[GAIN_W-1]}}, cfg.gain};
  assign in_mag   = item.sample[SMP_W-1] ? (~item.sample + SMP_W'(1)) : item.sample;
  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign qbit     = ~sum[ALU_W-1];
  assign clip     = (acc_r[ALU_W-1:SMP_W-1] != '0) || (acc_r[SMP_W-2:0] == '1);
  assign sat_mag  = clip ? SAT_LIMIT : {1'b0, acc_r[SMP_W-2:0]};

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_EMIT);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      peak_r  <= '0;
      sf_r    <= UNITY_Q16;
      pu_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      peak_r  <= peak_nxt;
      sf_r    <= sf_nxt;
      pu_r    <= pu_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    opd_r  <= opd_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    smag_r <= smag_nxt;
    neg_r  <= neg_nxt;
    last_r <= last_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    peak_nxt  = peak_r;
    sf_nxt    = sf_r;
    pu_nxt    = pu_r;
    acc_nxt   = acc_r;
    opd_nxt   = opd_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    smag_nxt  = smag_r;
    neg_nxt   = neg_r;
    last_nxt  = last_r;
    res_nxt   = res_r;
    op        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          smag_nxt = in_mag;
          neg_nxt  = item.sample[SMP_W-1];
          last_nxt = item.last;
          if (item.cmd == CMD_MEASURE) begin
            if (in_mag > peak_r) peak_nxt = in_mag;
            if (item.last) state_nxt = ST_LATCH;
          end else if (pu_r) begin
            acc_nxt   = ALU_W'(in_mag);
            state_nxt = ST_SAT;
          end else begin
            state_nxt = ST_FABS;
          end
        end
      end

      ST_LATCH: begin
        op.a   = gain_ext << 15;
        op.b   = gain_ext << 1;
        op.sub = 1'b1;
        if (!cfg.normalize_mode) begin
          sf_nxt    = SF_W'(gain_ext << 4);
          pu_nxt    = 1'b0;
          peak_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          opd_nxt   = sum;
          state_nxt = ST_DIFF;
        end
      end

      ST_DIFF: begin
        op.a      = ALU_W'(peak_r) << 12;
        op.b      = opd_r;
        op.sub    = 1'b1;
        acc_nxt   = sum;
        state_nxt = ST_ABS;
      end

      ST_ABS: begin
        op.b   = acc_r;
        op.sub = 1'b1;
        if (acc_r[ALU_W-1]) acc_nxt = sum;
        state_nxt = ST_TOL;
      end

      ST_TOL: begin
        op.a     = acc_r;
        op.b     = NORM_TOL;
        op.sub   = 1'b1;
        if (sum[ALU_W-1]) begin
          pu_nxt    = 1'b1;
          peak_nxt  = '0;
          state_nxt = ST_IDLE;
        end else if (peak_r == '0) begin
          pu_nxt    = 1'b0;
          sf_nxt    = SF_W'(gain_ext << 4);
          state_nxt = ST_IDLE;
        end else begin
          pu_nxt    = 1'b0;
          state_nxt = ST_NABS;
        end
      end

      ST_NABS: begin
        op.b   = opd_r;
        op.sub = 1'b1;
        if (opd_r[ALU_W-1]) opd_nxt = sum;
        state_nxt = ST_DVD;
      end

      // dividend is 2*|gain*32766*16| + peak
      ST_DVD: begin
        op.a      = opd_r << 5;
        op.b      = ALU_W'(peak_r);
        dvd_nxt   = sum[DVD_W-1:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end

      // restoring division by 2*peak, one quotient bit per cycle
      ST_DIV: begin
        op.a    = ALU_W'(rem_sh);
        op.b    = ALU_W'({peak_r, 1'b0});
        op.sub  = 1'b1;
        rem_nxt = qbit ? sum[REM_W-1:0] : rem_sh[REM_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], qbit};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) state_nxt = ST_SIGN;
      end

      ST_SIGN: begin
        op.b      = ALU_W'(dvd_r);
        op.sub    = cfg.gain[GAIN_W-1];
        sf_nxt    = sum[SF_W-1:0];
        peak_nxt  = '0;
        state_nxt = ST_IDLE;
      end

      ST_FABS: begin
        op.b      = {{(ALU_W-SF_W){sf_r[SF_W-1]}}, sf_r};
        op.sub    = sf_r[SF_W-1];
        opd_nxt   = sum;
        acc_nxt   = '0;
        dvd_nxt   = DVD_W'(smag_r);
        neg_nxt   = neg_r ^ sf_r[SF_W-1];
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end

      // shift-add multiply over the sample magnitude
      ST_MUL: begin
        op.a    = acc_r;
        op.b    = opd_r;
        if (dvd_r[0]) acc_nxt = sum;
        opd_nxt = opd_r << 1;
        dvd_nxt = dvd_r >> 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) state_nxt = ST_RND;
      end

      ST_RND: begin
        op.a      = acc_r;
        op.b      = RND_HALF;
        acc_nxt   = sum >> 16;
        state_nxt = ST_SAT;
      end

      ST_SAT: begin
        res_nxt.scaled    = neg_r ? (~sat_mag + SMP_W'(1)) : sat_mag;
        res_nxt.clipped   = clip;
        res_nxt.frame_end = last_r;
        state_nxt         = ST_EMIT;
      end

      ST_EMIT: begin
        if (res_ready) state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `PNGS_ASSERT_IMP(a_div_cnt, clk, rst_n, state_r == ST_DIV,
                   cnt_r < CNT_W'(DVD_W), "div count overrun")
  `PNGS_ASSERT_IMP(a_res_range, clk, rst_n, res_valid,
                   res.scaled != 16'h8000 && res.scaled != 16'h8001 &&
                   res.scaled != 16'h7FFF, "result out of range")
  `PNGS_ASSERT_IMP(a_clip_lim, clk, rst_n, res_valid && res.clipped,
                   res.scaled == SAT_POS || res.scaled == SAT_NEG, "clip without limit value")
  `PNGS_ASSERT_NXT(a_peak_clr, clk, rst_n, state_r == ST_SIGN,
                   peak_r == '0, "peak not cleared after latch")

endmodule

`default_nettype wire

// ===== hw/rtl/peak_normalize_gain_saturate_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Carries
// in_       tvalid tready tdata[15:0] tuser tlast   cmd, sample, last
// out_      tvalid tready tdata[15:0] tuser tlast   scaled, clipped, frame_end
// cfg_      we idx wdata[15:0]                      gain (0), normalize_mode (1)
//
// Measure transaction: peak update; with tlast, the factor is latched (gain mode) or
// found through diff, abs, tolerance and the bit-serial divider (normalize mode).
// Apply transaction: through the shared adder (16 multiply steps), rounding and
// saturation; samples that pass unchanged go straight to saturation.
// Reset is synchronous, active low; factor resets to unity, peak to zero.
// Output register frees the core while a result waits on out_tready.

module peak_normalize_gain_saturate_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [pngs_pkg::SMP_W-1:0]           in_tdata,   // sample
  input  logic                                 in_tuser,   // cmd
  input  logic                                 in_tlast,   // last
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [pngs_pkg::SMP_W-1:0]           out_tdata,  // scaled
  output logic                                 out_tuser,  // clipped
  output logic                                 out_tlast,  // frame_end
  input  logic                                 cfg_we,
  input  logic [pngs_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [pngs_pkg::GAIN_W-1:0]          cfg_wdata
);
  import pngs_pkg::*;

  cfg_t   cfg_r;
  item_t  item;
  res_t   res;
  res_t   out_r;
  logic   res_valid;
  logic   res_ready;
  logic   out_tvalid_r;

  assign item.cmd    = in_tuser;
  assign item.sample = in_tdata;
  assign item.last   = in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain           <= GAIN_RST;
      cfg_r.normalize_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GAIN: cfg_r.gain           <= cfg_wdata;
        CFG_MODE: cfg_r.normalize_mode <= cfg_wdata[0];
        default:  cfg_r                <= cfg_r;
      endcase
    end
  end

  pngs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_r.scaled;
  assign out_tuser  = out_r.clipped;
  assign out_tlast  = out_r.frame_end;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pngs_pkg::*;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [SMP_W-1:0]     in_tdata   = '0;   // sample
  logic                 in_tuser   = 1'b0; // cmd
  logic                 in_tlast   = 1'b0; // last
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [SMP_W-1:0]     out_tdata;         // scaled
  logic                 out_tuser;         // clipped
  logic                 out_tlast;         // frame_end
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx    = '0;
  logic [GAIN_W-1:0]    cfg_wdata  = '0;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int mismatch_cnt   = 0;
  int queued_cnt     = 0;

  item_t sample_q[$];
  res_t  scaled_exp_q[$];

  // predictor state
  logic signed [GAIN_W-1:0] gain_reg   = GAIN_RST;
  logic                     norm_mode  = 1'b0;
  logic [16:0]              peak_mag   = '0;
  logic signed [SF_W-1:0]   factor_q16 = UNITY_Q16;
  logic                     pass_thru  = 1'b0;

  peak_normalize_gain_saturate_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("peak_normalize_gain_saturate_top regression: fail");
    $finish;
  end

  function automatic void latch_factor();
    longint pk, diff, num, m, q;
    pk = longint'(peak_mag);
    if (!norm_mode) begin
      factor_q16 = SF_W'(longint'(gain_reg) * 16);
      pass_thru  = 1'b0;
      return;
    end
    diff = pk * 4096 - longint'(gain_reg) * 32766;
    if ((diff < 0 ? -diff : diff) < 134218) begin
      pass_thru = 1'b1;
      return;
    end
    pass_thru = 1'b0;
    if (pk == 0) begin
      factor_q16 = SF_W'(longint'(gain_reg) * 16);
    end else begin
      num = longint'(gain_reg) * 32766 * 16;
      m   = num < 0 ? -num : num;
      q   = (2 * m + pk) / (2 * pk);
      factor_q16 = SF_W'(num < 0 ? -q : q);
    end
  endfunction

  function automatic void predict_scaled(input logic cmd, input logic signed [SMP_W-1:0] smp,
                                         input logic lst);
    longint s, a, prod, r, ns;
    res_t   rs;
    s = smp;
    if (cmd == CMD_MEASURE) begin
      a = s < 0 ? -s : s;
      if (a > longint'(peak_mag)) peak_mag = 17'(a);
      if (lst) begin
        latch_factor();
        peak_mag = '0;
      end
      return;
    end
    if (pass_thru) begin
      ns = s;
    end else begin
      prod = s * longint'(factor_q16);
      r    = ((prod < 0 ? -prod : prod) + 32768) >> 16;
      ns   = prod < 0 ? -r : r;
    end
    rs.clipped = 1'b0;
    if (ns > 32766) begin
      ns = 32766;
      rs.clipped = 1'b1;
    end else if (ns < -32766) begin
      ns = -32766;
      rs.clipped = 1'b1;
    end
    rs.scaled    = 16'(ns);
    rs.frame_end = lst;
    scaled_exp_q.push_back(rs);
  endfunction

  // driver
  always @(posedge clk) begin
    item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = sample_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.cmd;
        in_tdata  <= nxt.sample;
        in_tlast  <= nxt.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_scaled(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got = {out_tdata, out_tuser, out_tlast};
        if (scaled_exp_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected transaction: scaled %0d clipped %0b frame_end %0b",
                     $signed(got.scaled), got.clipped, got.frame_end);
        end else begin
          want = scaled_exp_q.pop_front();
          if (got.scaled !== want.scaled || got.clipped !== want.clipped ||
              got.frame_end !== want.frame_end) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                       $signed(want.scaled), want.clipped, want.frame_end,
                       $signed(got.scaled), got.clipped, got.frame_end);
          end
        end
      end
    end
  end

  function automatic void push(input logic cmd, input logic [SMP_W-1:0] s, input logic lst);
    item_t it;
    it.cmd    = cmd;
    it.sample = s;
    it.last   = lst;
    sample_q.push_back(it);
    queued_cnt++;
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(7))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h7FFE;
          3: return 16'h8001;
          4: return 16'h8002;
          5: return 16'h0000;
          6: return 16'h0001;
          default: return 16'hFFFF;
        endcase
      end
      1, 2, 3: return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // measure pass then apply pass; in normalise mode often lands the peak near target
  task automatic push_frame();
    int          n_meas, n_app, pick, tgt, mag;
    bit          near, zeros;
    logic [15:0] s;
    n_meas = $urandom_range(1, 6);
    n_app  = $urandom_range(1, 8);
    tgt    = (int'(gain_reg) * 32766) / 4096;
    near   = norm_mode && tgt >= 0 && tgt <= 32768 && $urandom_range(1) == 0;
    zeros  = ($urandom_range(15) == 0);
    pick   = $urandom_range(n_meas - 1);
    for (int i = 0; i < n_meas; i++) begin
      if (zeros) begin
        s = '0;
      end else if (near) begin
        if (i == pick) mag = tgt - 40 + int'($urandom_range(80));
        else mag = int'($urandom_range(tgt / 2));
        if (mag < 0) mag = 0;
        if (mag > 32768) mag = 32768;
        if (mag == 32768) s = 16'h8000;
        else s = $urandom_range(1) ? 16'(-mag) : 16'(mag);
      end else begin
        s = rand_sample();
      end
      push(CMD_MEASURE, s, i == n_meas - 1);
    end
    for (int j = 0; j < n_app; j++) push(CMD_APPLY, rand_sample(), j == n_app - 1);
  endtask

  task automatic wait_quiet();
    while (sample_q.size() != 0 || in_tvalid || scaled_exp_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GAIN) gain_reg = data;
    else norm_mode = data[0];
  endtask

  initial begin
    int          start;
    logic [15:0] g;
    logic        md;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // apply before any measure: reset factor
    push(CMD_APPLY, 16'h7FFF, 1'b0);
    push(CMD_APPLY, 16'h8000, 1'b0);
    push(CMD_APPLY, 16'h0000, 1'b0);
    push(CMD_APPLY, 16'hFFFF, 1'b1);
    push(CMD_MEASURE, 16'd100, 1'b0);
    push(CMD_MEASURE, 16'h8000, 1'b1);
    push(CMD_APPLY, 16'd12345, 1'b1);
    wait_quiet();
    // minus unity
    write_reg(CFG_GAIN, -16'sd4096);
    push(CMD_MEASURE, 16'd5, 1'b1);
    push(CMD_APPLY, 16'h7FFF, 1'b0);
    push(CMD_APPLY, 16'h8000, 1'b1);
    wait_quiet();
    // zero peak in normalise mode
    write_reg(CFG_GAIN, 16'd4096);
    write_reg(CFG_MODE, 16'd1);
    push(CMD_MEASURE, 16'd0, 1'b0);
    push(CMD_MEASURE, 16'd0, 1'b1);
    push(CMD_APPLY, 16'd777, 1'b1);
    wait_quiet();
    // peak already on target: unchanged path with clamp
    push(CMD_MEASURE, 16'h7FFF, 1'b1);
    push(CMD_APPLY, 16'h8000, 1'b0);
    push(CMD_APPLY, 16'h7FFF, 1'b0);
    push(CMD_APPLY, 16'd100, 1'b1);
    wait_quiet();
    write_reg(CFG_GAIN, 16'h7FFF);
    push(CMD_MEASURE, 16'd1, 1'b1);
    push(CMD_APPLY, 16'd1, 1'b0);
    push(CMD_APPLY, 16'hFFFF, 1'b0);
    push(CMD_APPLY, 16'd0, 1'b1);
    wait_quiet();
    write_reg(CFG_GAIN, 16'h8000);
    push(CMD_MEASURE, 16'h8000, 1'b1);
    push(CMD_APPLY, 16'h7FFF, 1'b0);
    push(CMD_APPLY, 16'h8000, 1'b1);

    for (int p = 0; p < 8; p++) begin
      wait_quiet();
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 85; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 85; end
        default: begin src_idle_pct = 36; sink_stall_pct = 36; end
      endcase
      case (p)
        0: begin g = 16'd4096;                     md = 1'b0; end
        1: begin g = 16'h7FFF;                     md = 1'b1; end
        2: begin g = 16'h8000;                     md = 1'b0; end
        3: begin g = 16'($urandom_range(1, 4096)); md = 1'b1; end
        4: begin g = 16'd0;                        md = 1'b1; end
        5: begin g = 16'($urandom);                md = 1'b0; end
        6: begin g = 16'($urandom_range(1, 32767)); md = 1'b1; end
        default: begin g = 16'h8000;               md = 1'b1; end
      endcase
      write_reg(CFG_GAIN, g);
      write_reg(CFG_MODE, {15'd0, md});
      start = queued_cnt;
      while (queued_cnt - start < 128) begin
        if ($urandom_range(6) == 0)
          push(1'($urandom_range(1)), rand_sample(), 1'($urandom_range(1)));
        else
          push_frame();
      end
    end

    wait_quiet();
    if (mismatch_cnt == 0 && scaled_exp_q.size() == 0) begin
      $display("peak_normalize_gain_saturate_top regression: pass");
    end else begin
      $display("peak_normalize_gain_saturate_top regression: fail");
    end
    $finish;
  end

endmodule
